@@ hw/rtl/sds_pkg.sv @@
// Shared dual stack: package with payload types, command and status codes,
// and the operation kinds passed from the front end to the back end.
// No dependencies.
package sds_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int QUEUE_DEPTH   = 2;

    // Input commands
    localparam logic [1:0] CMD_PUSH_LOW  = 2'd0;
    localparam logic [1:0] CMD_PUSH_HIGH = 2'd1;
    localparam logic [1:0] CMD_DUMP      = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ENTRY  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_word;
        logic                     from_high;
        logic                     last;
    } out_item_t;

    // Classified operation, one per queued transaction
    typedef enum logic [2:0] {
        OP_PUSH_LOW  = 3'd0,
        OP_PUSH_HIGH = 3'd1,
        OP_FULL      = 3'd2,
        OP_EMPTY     = 3'd3,
        OP_DUMP      = 3'd4
    } op_kind_t;

endpackage

@@ hw/rtl/sds_ram.sv @@
// Shared dual stack: generic simple dual-port RAM, one write port and one
// read port with registered read data that holds while no read is issued.
// No dependencies.
module sds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sds_front.sv @@
// Shared dual stack: front end. Accepts input transactions, tracks the stack
// counts, writes pushed words to the RAM and queues a classified operation.
// Depends on sds_pkg.
module sds_front #(
    parameter int DEPTH = sds_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sds_pkg::in_item_t          in_item,
    output logic                       q_push,
    output sds_pkg::op_kind_t          q_kind,
    input  logic                       q_full,
    output logic                       ram_we,
    output logic [$clog2(DEPTH)-1:0]   ram_waddr,
    output logic [sds_pkg::DATA_W-1:0] ram_wdata
);

    import sds_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] low_cnt_reg, low_cnt_next;
    logic [CW-1:0] high_cnt_reg, high_cnt_next;
    logic [CW:0]   total;
    logic          is_full;
    logic          is_empty;
    logic          accept;
    logic [CW-1:0] high_waddr;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify against the current occupancy
    assign total    = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign is_full  = (total == (CW + 1)'(DEPTH));
    assign is_empty = (total == '0);

    // Next free entry of the high stack, counted down from the top
    assign high_waddr = CW'(DEPTH) - high_cnt_reg - CW'(1);

    // Decode the command, write the RAM and pick the queued operation
    always_comb
    begin
        q_push        = 1'b0;
        q_kind        = OP_EMPTY;
        ram_we        = 1'b0;
        ram_waddr     = low_cnt_reg[AW-1:0];
        ram_wdata     = in_item.value;
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        if (accept)
        begin
            case (in_item.command)
                CMD_PUSH_LOW:
                begin
                    q_push = 1'b1;
                    if (is_full)
                    begin
                        q_kind = OP_FULL;
                    end
                    else
                    begin
                        q_kind       = OP_PUSH_LOW;
                        ram_we       = 1'b1;
                        low_cnt_next = low_cnt_reg + CW'(1);
                    end
                end
                CMD_PUSH_HIGH:
                begin
                    q_push = 1'b1;
                    if (is_full)
                    begin
                        q_kind = OP_FULL;
                    end
                    else
                    begin
                        q_kind        = OP_PUSH_HIGH;
                        ram_we        = 1'b1;
                        ram_waddr     = high_waddr[AW-1:0];
                        high_cnt_next = high_cnt_reg + CW'(1);
                    end
                end
                CMD_DUMP:
                begin
                    q_push = 1'b1;
                    q_kind = is_empty ? OP_EMPTY : OP_DUMP;
                end
                default:
                begin
                    // Unused command: drop without a result
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // Hold the stack counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

    // The two stacks never hold more than the store
    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CW + 1)'(DEPTH))
        else $error("stack occupancy exceeds store depth");

    // A successful push always writes the store
    a_push_writes: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && (q_kind == OP_PUSH_LOW || q_kind == OP_PUSH_HIGH) |-> ram_we)
        else $error("push queued without store write");

endmodule

@@ hw/rtl/sds_queue.sv @@
// Shared dual stack: short queue of classified operations between the front
// end and the back end.
// Depends on sds_pkg.
module sds_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sds_pkg::op_kind_t push_kind,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output sds_pkg::op_kind_t head_kind
);

    import sds_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    op_kind_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (fill_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_kind  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_kind;
        end
    end

    // Fill level never passes the queue depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NW'(QUEUE_DEPTH))
        else $error("operation queue overfilled");

endmodule

@@ hw/rtl/sds_back.sv @@
// Shared dual stack: back end. Carries out queued operations, walks the
// stacks for a dump through the RAM read port and drives the result register.
// Depends on sds_pkg.
module sds_back #(
    parameter int DEPTH = sds_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  sds_pkg::op_kind_t          q_kind,
    output logic                       q_pop,
    output logic                       ram_re,
    output logic [$clog2(DEPTH)-1:0]   ram_raddr,
    input  logic [sds_pkg::DATA_W-1:0] ram_rdata,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sds_pkg::out_item_t         out_item
);

    import sds_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_DUMP = 2'b10
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] lcnt_reg, lcnt_next;
    logic [CW-1:0] hcnt_reg, hcnt_next;
    logic [CW-1:0] low_left_reg, low_left_next;
    logic [CW-1:0] high_left_reg, high_left_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          pend_high_reg;
    logic          pend_last_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg;

    logic          out_free;
    logic          head_dump;
    logic          issue;
    logic          issue_last;
    logic          low_phase;
    logic          load_entry;
    logic          load_single;
    logic [CW-1:0] hi_start_dump;
    logic [CW-1:0] hi_start_idle;
    logic [CW-1:0] low_top;
    out_item_t     single_item;

    assign out_free  = !out_valid_reg || out_ready;
    assign head_dump = (q_kind == OP_DUMP);

    // Take a queued operation; a single result waits for pending dump data
    assign q_pop = q_valid && (state_reg == B_IDLE)
                   && (head_dump || (!rd_pend_reg && out_free));
    assign load_single = q_pop && !head_dump;

    // Issue a read when the previous read data leaves this cycle or is gone
    assign low_phase  = (low_left_reg != '0);
    assign issue      = (state_reg == B_DUMP) && (!rd_pend_reg || out_free);
    assign issue_last = low_phase ? (low_left_reg == CW'(1) && high_left_reg == '0)
                                  : (high_left_reg == CW'(1));
    assign load_entry = rd_pend_reg && out_free;

    assign hi_start_dump = CW'(DEPTH) - high_left_reg;
    assign hi_start_idle = CW'(DEPTH) - hcnt_reg;
    assign low_top       = lcnt_reg - CW'(1);

    assign ram_re    = issue;
    assign ram_raddr = addr_reg;

    // Result for operations that give a single transaction
    always_comb
    begin
        single_item           = '0;
        single_item.last      = 1'b1;
        case (q_kind)
            OP_PUSH_LOW:  single_item.status = ST_PUSHED;
            OP_PUSH_HIGH: single_item.status = ST_PUSHED;
            OP_FULL:      single_item.status = ST_FULL;
            OP_EMPTY:     single_item.status = ST_EMPTY;
            default:      single_item.status = ST_EMPTY;
        endcase
    end

    // Sequence the dump walk and mirror the stack counts
    always_comb
    begin
        state_next     = state_reg;
        lcnt_next      = lcnt_reg;
        hcnt_next      = hcnt_reg;
        low_left_next  = low_left_reg;
        high_left_next = high_left_reg;
        addr_next      = addr_reg;
        rd_pend_next   = issue || (rd_pend_reg && !out_free);
        out_valid_next = out_valid_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_kind)
                        OP_PUSH_LOW:  lcnt_next = lcnt_reg + CW'(1);
                        OP_PUSH_HIGH: hcnt_next = hcnt_reg + CW'(1);
                        OP_DUMP:
                        begin
                            state_next     = B_DUMP;
                            low_left_next  = lcnt_reg;
                            high_left_next = hcnt_reg;
                            addr_next      = (lcnt_reg != '0) ? low_top[AW-1:0]
                                                              : hi_start_idle[AW-1:0];
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_DUMP:
            begin
                if (issue)
                begin
                    if (low_phase)
                    begin
                        low_left_next = low_left_reg - CW'(1);
                        addr_next     = (low_left_reg == CW'(1)) ? hi_start_dump[AW-1:0]
                                                                 : addr_reg - AW'(1);
                    end
                    else
                    begin
                        high_left_next = high_left_reg - CW'(1);
                        addr_next      = addr_reg + AW'(1);
                    end
                    if (issue_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // Output register handshake
        if (load_entry || load_single)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            lcnt_reg      <= '0;
            hcnt_reg      <= '0;
            low_left_reg  <= '0;
            high_left_reg <= '0;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcnt_reg      <= lcnt_next;
            hcnt_reg      <= hcnt_next;
            low_left_reg  <= low_left_next;
            high_left_reg <= high_left_next;
            addr_reg      <= addr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Tag each read and load the result payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_high_reg <= !low_phase;
            pend_last_reg <= issue_last;
        end
        if (load_entry)
        begin
            out_item_reg.status    <= ST_ENTRY;
            out_item_reg.data_word <= ram_rdata;
            out_item_reg.from_high <= pend_high_reg;
            out_item_reg.last      <= pend_last_reg;
        end
        else if (load_single)
        begin
            out_item_reg <= single_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Read data waiting on a stalled output is kept for the next cycle
    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg && !out_free |=> rd_pend_reg)
        else $error("pending dump entry lost");

    // A dump walk always has an entry left to read
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DUMP |-> (low_left_reg != '0 || high_left_reg != '0))
        else $error("dump walk with no entries left");

    // Front and back agree that a dump has something to read
    a_counts_agree: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_kind == OP_DUMP |-> (lcnt_reg != '0 || hcnt_reg != '0))
        else $error("dump queued on empty mirrored counts");

endmodule

@@ hw/rtl/shared_dual_stack_top.sv @@
// Shared dual stack: top level. Connects front end, operation queue, back
// end and the shared store RAM.
// Depends on sds_pkg, sds_ram, sds_front, sds_queue, sds_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_ready    | in_item  (command, value)
//  output   | out_valid / out_ready  | out_item (status, data_word, from_high, last)
//
// A push or an empty dump is taken every cycle while the queue has room and
// gives its result through the queue and the output register.
// A dump holds the back end until all its entries are read; the single RAM read
// port sets the pace of one entry per cycle unless the output stalls, and the
// front keeps taking transactions during a dump until the two-entry queue fills.
// Reset clears the counts and control state; the store is not cleared.
// Output stalls back up through the queue to in_ready.
module shared_dual_stack_top #(
    parameter int DEPTH = sds_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sds_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sds_pkg::out_item_t out_item
);

    import sds_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              q_push;
    op_kind_t          q_push_kind;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    op_kind_t          q_head_kind;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    sds_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .q_push    (q_push),
        .q_kind    (q_push_kind),
        .q_full    (q_full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    sds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_kind  (q_push_kind),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_kind  (q_head_kind)
    );

    sds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sds_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_kind    (q_head_kind),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
